[rtl/core/tmr_pkg.sv]
package tmr_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_CAP   = 16;
  localparam int SLOT_COUNT = (NUM_SLOTS > SLOT_CAP) ? SLOT_CAP : NUM_SLOTS;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TICK_W     = 32;
  localparam int SLOT_W     = 4;
  localparam int KIND_W     = 2;
  localparam int S_DATA_W   = 72;
  localparam int M_DATA_W   = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PROCESS = 2'd0,
    KIND_START   = 2'd1,
    KIND_STOP    = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_t;

  // Write request into the slot store.
  typedef struct packed {
    logic              exp_we;
    logic              start_we;
    logic              disarm;
    logic [IDX_W-1:0]  idx;
    logic [TICK_W-1:0] expiry;
    logic [TICK_W-1:0] period;
    logic              reload;
  } st_wr_t;

  // Contents of the slot selected for reading.
  typedef struct packed {
    logic [TICK_W-1:0] expiry;
    logic [TICK_W-1:0] period;
    logic              reload;
    logic              armed;
  } st_rd_t;

endpackage

[rtl/core/tmr_alu.sv]
module tmr_alu
  import tmr_pkg::*;
(
  input  logic [TICK_W-1:0] a,
  input  logic [TICK_W-1:0] b,
  input  logic              sub,
  output logic [TICK_W-1:0] sum
);

  // One adder serves both now + delay and the wrap-safe now - expiry test.
  assign sum = a + (b ^ {TICK_W{sub}}) + TICK_W'(sub);

endmodule

[rtl/core/tmr_store.sv]
module tmr_store
  import tmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  st_wr_t                wr,
  input  logic [IDX_W-1:0]      rd_idx,
  output st_rd_t                rd,
  output logic [SLOT_COUNT-1:0] armed
);

  logic [TICK_W-1:0]     expiry_mem [SLOT_COUNT];
  logic [TICK_W-1:0]     period_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] reload_flag;

  // Expiry and period are only looked at while a slot is armed, and arming
  // always writes both, so they need no reset.
  always_ff @(posedge clk) begin
    if (wr.exp_we) begin
      expiry_mem[wr.idx] <= wr.expiry;
    end
    if (wr.start_we) begin
      period_mem[wr.idx] <= wr.period;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= '0;
      reload_flag <= '0;
    end else if (wr.start_we) begin
      armed[wr.idx]       <= 1'b1;
      reload_flag[wr.idx] <= wr.reload;
    end else if (wr.disarm) begin
      armed[wr.idx] <= 1'b0;
    end
  end

  assign rd.expiry = expiry_mem[rd_idx];
  assign rd.period = period_mem[rd_idx];
  assign rd.reload = reload_flag[rd_idx];
  assign rd.armed  = armed[rd_idx];

endmodule

[rtl/core/multi_slot_software_timer.sv]
// Bank of SLOT_COUNT software timer slots driven by one word per command.
// Start, stop and query pass through an execute state and then a response
// state before a result is loaded. A process command scans the slots one per
// cycle through a single shared 32-bit adder, detours through a reload state
// for each periodic slot that reloads, then walks the slots again up to the
// highest expired one, one per cycle while the output is not stalled, placing
// one result word per expired slot (or one empty word if none). The input is
// not ready again until the last result word of a command has been loaded.
module multi_slot_software_timer
  import tmr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // slot[3:0], interval[35:4], periodic[36],
                                        // now_tick[68:37], zero fill
  input  logic [KIND_W-1:0]   s_tuser,  // kind
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // fired_slot[3:0], slot_active[4],
                                        // any_active[5], zero fill
  output logic                m_tuser,  // fired
  output logic                m_tlast   // last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_RELOAD,
    ST_EMIT,
    ST_RESP
  } state_t;

  state_t                state;
  kind_t                 kind;
  logic [SLOT_W-1:0]     slot;
  logic [TICK_W-1:0]     interval;
  logic                  periodic;
  logic [TICK_W-1:0]     now_tick;
  logic [IDX_W-1:0]      idx;
  logic [SLOT_COUNT-1:0] hits;
  logic                  resp_empty;

  st_wr_t                wr;
  st_rd_t                rd;
  logic [SLOT_COUNT-1:0] armed;
  logic [IDX_W-1:0]      rd_idx;
  logic [TICK_W-1:0]     alu_a;
  logic [TICK_W-1:0]     alu_b;
  logic                  alu_sub;
  logic [TICK_W-1:0]     alu_sum;

  logic                  slot_ok;
  logic                  out_free;
  logic                  out_load;
  logic                  any_active;
  logic                  hit;
  logic                  last_idx;
  logic [SLOT_COUNT-1:0] hits_next;
  logic [SLOT_COUNT-1:0] remaining;

  tmr_store u_store (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_idx (rd_idx),
    .rd     (rd),
    .armed  (armed)
  );

  tmr_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  assign s_tready   = (state == ST_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign out_load   = ((state == ST_EMIT) && hits[idx] && out_free) ||
                      ((state == ST_RESP) && out_free);
  assign slot_ok    = {1'b0, slot} < (SLOT_W + 1)'(SLOT_COUNT);
  assign any_active = |armed;
  assign rd_idx     = (state == ST_EXEC) ? slot[IDX_W-1:0] : idx;
  assign last_idx   = (idx == IDX_W'(SLOT_COUNT - 1));

  // A slot has expired when now - expiry, taken modulo 2^32, is not negative.
  assign hit       = (state == ST_SCAN) && rd.armed && !alu_sum[TICK_W-1];
  assign hits_next = hits | (hit ? (SLOT_COUNT'(1) << idx) : '0);
  assign remaining = hits & ~(SLOT_COUNT'(1) << idx);

  always_comb begin
    alu_a   = now_tick;
    alu_b   = interval;
    alu_sub = 1'b0;
    case (state)
      ST_SCAN: begin
        alu_b   = rd.expiry;
        alu_sub = 1'b1;
      end
      ST_RELOAD: begin
        alu_b = rd.period;
      end
      default: begin
        alu_b = interval;
      end
    endcase
  end

  always_comb begin
    wr          = '0;
    wr.idx      = rd_idx;
    wr.expiry   = alu_sum;
    wr.period   = interval;
    wr.reload   = periodic;
    case (state)
      ST_EXEC: begin
        if (slot_ok && kind == KIND_START) begin
          wr.exp_we   = 1'b1;
          wr.start_we = 1'b1;
        end else if (slot_ok && kind == KIND_STOP) begin
          wr.disarm = 1'b1;
        end
      end
      ST_SCAN: begin
        wr.disarm = hit && !rd.reload;
      end
      ST_RELOAD: begin
        wr.exp_we = 1'b1;
      end
      default: begin
        wr.exp_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      idx      <= '0;
      hits     <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            kind       <= kind_t'(s_tuser);
            slot       <= s_tdata[3:0];
            interval   <= s_tdata[35:4];
            periodic   <= s_tdata[36];
            now_tick   <= s_tdata[68:37];
            idx        <= '0;
            hits       <= '0;
            resp_empty <= 1'b0;
            state      <= (kind_t'(s_tuser) == KIND_PROCESS) ? ST_SCAN : ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_RESP;
        end
        ST_SCAN, ST_RELOAD: begin
          hits <= hits_next;
          if (hit && rd.reload) begin
            state <= ST_RELOAD;
          end else if (!last_idx) begin
            idx   <= idx + 1'b1;
            state <= ST_SCAN;
          end else if (hits_next == '0) begin
            resp_empty <= 1'b1;
            state      <= ST_RESP;
          end else begin
            idx   <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!hits[idx]) begin
            idx <= idx + 1'b1;
          end else if (out_free) begin
            m_tdata   <= {{(M_DATA_W - SLOT_W - 2){1'b0}}, any_active, armed[idx],
                          SLOT_W'(idx)};
            m_tuser   <= 1'b1;
            m_tlast   <= (remaining == '0);
            hits[idx] <= 1'b0;
            if (remaining == '0) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_RESP: begin
          if (out_free) begin
            m_tdata <= {{(M_DATA_W - SLOT_W - 2){1'b0}}, any_active,
                        !resp_empty && slot_ok && armed[slot[IDX_W-1:0]],
                        (resp_empty ? {SLOT_W{1'b0}} : slot)};
            m_tuser <= 1'b0;
            m_tlast <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/tmr_check.sv]
module tmr_check
  import tmr_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tuser,
  input logic                m_tlast
);

  // A command is worked on alone: the input closes right after acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a word was accepted");

  // A result that reports no expiry is always the only word of its command.
  a_plain_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("non-expiry result without last");

  // A reply that shows its slot active must also show the bank as active.
  a_active_implies_any: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && m_tdata[4] |-> m_tdata[5])
    else $error("slot reported active while no slot is active");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind multi_slot_software_timer tmr_check u_tmr_check (.*);
